// File: hdl/two_level_group_sum_with_max_core_defines.svh
// Assertion macros shared by the checker of the group sum core.
`ifndef TWO_LEVEL_GROUP_SUM_WITH_MAX_CORE_DEFINES_SVH
`define TWO_LEVEL_GROUP_SUM_WITH_MAX_CORE_DEFINES_SVH

// Clocked on clk, ignored while rst_n is low.
`define TLGS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlgs assertion failed");

// Clocked on clk, checked during reset as well.
`define TLGS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlgs reset assertion failed");

`endif

// File: hdl/tlgs_pkg.sv
// Shared types and constants of the two-level group sum core.
package tlgs_pkg;

  localparam int KEY_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF = 48;
  localparam int AMOUNT_WIDTH  = 32;
  localparam int N_SLOTS       = 3;
  localparam int CNT_WIDTH     = 2;

  typedef enum logic [1:0] {
    KIND_DEPT   = 2'd0,
    KIND_BRANCH = 2'd1,
    KIND_GRAND  = 2'd2
  } tlgs_kind_t;

endpackage

// File: hdl/tlgs_in_if.sv
// Input request channel: records and end-of-stream markers.
interface tlgs_in_if #(
  parameter int KEY_WIDTH = tlgs_pkg::KEY_WIDTH_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic [KEY_WIDTH-1:0]                  branch;
  logic [KEY_WIDTH-1:0]                  department;
  logic signed [tlgs_pkg::AMOUNT_WIDTH-1:0] amount;

  modport source (output valid, action, branch, department, amount, input ready);
  modport sink   (input valid, action, branch, department, amount, output ready);
endinterface

// File: hdl/tlgs_out_if.sv
// Result request channel: department, branch and grand totals.
interface tlgs_out_if #(
  parameter int KEY_WIDTH = tlgs_pkg::KEY_WIDTH_DEF,
  parameter int SUM_WIDTH = tlgs_pkg::SUM_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  tlgs_pkg::tlgs_kind_t        kind;
  logic [KEY_WIDTH-1:0]        branch_res;
  logic [KEY_WIDTH-1:0]        department_res;
  logic signed [SUM_WIDTH-1:0] total;
  logic                        max_valid;
  logic [KEY_WIDTH-1:0]        max_branch;
  logic [KEY_WIDTH-1:0]        max_department;
  logic                        last;

  modport source (output valid, kind, branch_res, department_res, total, max_valid,
                  max_branch, max_department, last, input ready);
  modport sink   (input valid, kind, branch_res, department_res, total, max_valid,
                  max_branch, max_department, last, output ready);
endinterface

// File: hdl/tlgs_acc.sv
// Running sums, group keys and largest department; builds the results of one request.
module tlgs_acc #(
  parameter int KEY_WIDTH = tlgs_pkg::KEY_WIDTH_DEF,
  parameter int SUM_WIDTH = tlgs_pkg::SUM_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     take,
  input  logic                                     action,
  input  logic [KEY_WIDTH-1:0]                     branch,
  input  logic [KEY_WIDTH-1:0]                     department,
  input  logic signed [tlgs_pkg::AMOUNT_WIDTH-1:0] amount,
  output logic [tlgs_pkg::CNT_WIDTH-1:0]           res_cnt,
  output tlgs_pkg::tlgs_kind_t                     res_kind   [tlgs_pkg::N_SLOTS],
  output logic [KEY_WIDTH-1:0]                     res_branch [tlgs_pkg::N_SLOTS],
  output logic [KEY_WIDTH-1:0]                     res_dept   [tlgs_pkg::N_SLOTS],
  output logic [SUM_WIDTH-1:0]                     res_total  [tlgs_pkg::N_SLOTS],
  output logic                                     res_max_valid,
  output logic [KEY_WIDTH-1:0]                     res_max_branch,
  output logic [KEY_WIDTH-1:0]                     res_max_dept
);

  logic                 open_r, open_nxt;
  logic [KEY_WIDTH-1:0] cur_br_r, cur_br_nxt;
  logic [KEY_WIDTH-1:0] cur_dp_r, cur_dp_nxt;
  logic [SUM_WIDTH-1:0] dept_sum_r, dept_sum_nxt;
  logic [SUM_WIDTH-1:0] br_sum_r, br_sum_nxt;
  logic [SUM_WIDTH-1:0] grand_sum_r, grand_sum_nxt;
  logic                 best_valid_r, best_valid_nxt;
  logic [SUM_WIDTH-1:0] best_sum_r, best_sum_nxt;
  logic [KEY_WIDTH-1:0] best_br_r, best_br_nxt;
  logic [KEY_WIDTH-1:0] best_dp_r, best_dp_nxt;

  logic                 eos;
  logic                 br_chg;
  logic                 close_dept;
  logic                 close_br;
  logic                 better;
  logic [SUM_WIDTH-1:0] amt_ext;
  logic [SUM_WIDTH-1:0] br_close_tot;
  logic [SUM_WIDTH-1:0] grand_close_tot;
  logic                 upd_valid;
  logic [SUM_WIDTH-1:0] upd_sum;
  logic [KEY_WIDTH-1:0] upd_br;
  logic [KEY_WIDTH-1:0] upd_dp;

  assign eos     = action;
  assign amt_ext = SUM_WIDTH'(amount);
  assign br_chg  = (branch != cur_br_r);

  // A branch change closes the department too, even with the same department id.
  assign close_dept = open_r && (eos || br_chg || (department != cur_dp_r));
  assign close_br   = open_r && (eos || br_chg);

  // Sums other than the open ones are zero, so the closing totals need no gating.
  assign br_close_tot    = br_sum_r + dept_sum_r;
  assign grand_close_tot = grand_sum_r + br_close_tot;

  // Ties keep the earlier department.
  assign better = !best_valid_r || ($signed(dept_sum_r) > $signed(best_sum_r));

  always_comb begin
    upd_valid = best_valid_r;
    upd_sum   = best_sum_r;
    upd_br    = best_br_r;
    upd_dp    = best_dp_r;
    if (close_dept && better) begin
      upd_valid = 1'b1;
      upd_sum   = dept_sum_r;
      upd_br    = cur_br_r;
      upd_dp    = cur_dp_r;
    end
  end

  // Slot 0 holds the department total, or the grand total when nothing closes.
  always_comb begin
    res_cnt = tlgs_pkg::CNT_WIDTH'(close_dept) + tlgs_pkg::CNT_WIDTH'(close_br)
            + tlgs_pkg::CNT_WIDTH'(eos);

    res_kind[0]   = close_dept ? tlgs_pkg::KIND_DEPT : tlgs_pkg::KIND_GRAND;
    res_branch[0] = close_dept ? cur_br_r : '0;
    res_dept[0]   = close_dept ? cur_dp_r : '0;
    res_total[0]  = close_dept ? dept_sum_r : grand_close_tot;

    res_kind[1]   = tlgs_pkg::KIND_BRANCH;
    res_branch[1] = cur_br_r;
    res_dept[1]   = '0;
    res_total[1]  = br_close_tot;

    res_kind[2]   = tlgs_pkg::KIND_GRAND;
    res_branch[2] = '0;
    res_dept[2]   = '0;
    res_total[2]  = grand_close_tot;

    res_max_valid  = upd_valid;
    res_max_branch = upd_valid ? upd_br : '0;
    res_max_dept   = upd_valid ? upd_dp : '0;
  end

  always_comb begin
    open_nxt       = open_r;
    cur_br_nxt     = cur_br_r;
    cur_dp_nxt     = cur_dp_r;
    dept_sum_nxt   = dept_sum_r;
    br_sum_nxt     = br_sum_r;
    grand_sum_nxt  = grand_sum_r;
    best_valid_nxt = best_valid_r;
    best_sum_nxt   = best_sum_r;
    best_br_nxt    = best_br_r;
    best_dp_nxt    = best_dp_r;
    if (take) begin
      if (eos) begin
        // End of stream: drop everything back to reset values.
        open_nxt       = 1'b0;
        cur_br_nxt     = '0;
        cur_dp_nxt     = '0;
        dept_sum_nxt   = '0;
        br_sum_nxt     = '0;
        grand_sum_nxt  = '0;
        best_valid_nxt = 1'b0;
        best_sum_nxt   = '0;
        best_br_nxt    = '0;
        best_dp_nxt    = '0;
      end else begin
        open_nxt       = 1'b1;
        cur_br_nxt     = branch;
        cur_dp_nxt     = department;
        dept_sum_nxt   = (close_dept ? '0 : dept_sum_r) + amt_ext;
        best_valid_nxt = upd_valid;
        best_sum_nxt   = upd_sum;
        best_br_nxt    = upd_br;
        best_dp_nxt    = upd_dp;
        if (close_br) begin
          br_sum_nxt    = '0;
          grand_sum_nxt = grand_close_tot;
        end else if (close_dept) begin
          br_sum_nxt = br_close_tot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      cur_br_r     <= '0;
      cur_dp_r     <= '0;
      dept_sum_r   <= '0;
      br_sum_r     <= '0;
      grand_sum_r  <= '0;
      best_valid_r <= 1'b0;
      best_sum_r   <= '0;
      best_br_r    <= '0;
      best_dp_r    <= '0;
    end else begin
      open_r       <= open_nxt;
      cur_br_r     <= cur_br_nxt;
      cur_dp_r     <= cur_dp_nxt;
      dept_sum_r   <= dept_sum_nxt;
      br_sum_r     <= br_sum_nxt;
      grand_sum_r  <= grand_sum_nxt;
      best_valid_r <= best_valid_nxt;
      best_sum_r   <= best_sum_nxt;
      best_br_r    <= best_br_nxt;
      best_dp_r    <= best_dp_nxt;
    end
  end

endmodule

// File: hdl/two_level_group_sum_with_max_core.sv
// Top level of the two-level group sum core with largest department.
//
//   channel  | direction | handshake          | carries
//   in_chan  | sink      | valid/ready        | action, branch, department, amount
//   out_chan | source    | valid/ready        | kind, keys, total, largest dept, last
//
// A request is taken on a valid/ready handshake; its results sit in a three-slot
// result register the next cycle and leave one per cycle while out_chan.ready
// is high, so a request that yields several results holds in_chan.ready low
// until only its final result is left and being taken.
// Requests yielding at most one result flow at one per cycle while out_chan is
// ready; in_chan.ready stays high while the slot register is empty or holds its
// final result being taken. Reset (synchronous, rst_n low) clears all sums and
// empties the slots. Stalls on out_chan hold the head result and back-pressure input.
module two_level_group_sum_with_max_core #(
  parameter int KEY_WIDTH = tlgs_pkg::KEY_WIDTH_DEF,
  parameter int SUM_WIDTH = tlgs_pkg::SUM_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tlgs_in_if.sink    in_chan,
  tlgs_out_if.source out_chan
);

  typedef struct packed {
    tlgs_pkg::tlgs_kind_t kind;
    logic [KEY_WIDTH-1:0] br;
    logic [KEY_WIDTH-1:0] dp;
    logic [SUM_WIDTH-1:0] tot;
    logic                 mv;
    logic [KEY_WIDTH-1:0] mb;
    logic [KEY_WIDTH-1:0] md;
    logic                 last;
  } slot_t;

  localparam int NS = tlgs_pkg::N_SLOTS;
  localparam int CW = tlgs_pkg::CNT_WIDTH;

  slot_t          slot_r   [NS];
  slot_t          slot_nxt [NS];
  slot_t          fresh    [NS];
  logic [CW-1:0]  cnt_r, cnt_nxt;

  logic                 take;
  logic                 pop;
  logic [CW-1:0]        res_cnt;
  tlgs_pkg::tlgs_kind_t res_kind   [NS];
  logic [KEY_WIDTH-1:0] res_branch [NS];
  logic [KEY_WIDTH-1:0] res_dept   [NS];
  logic [SUM_WIDTH-1:0] res_total  [NS];
  logic                 res_max_valid;
  logic [KEY_WIDTH-1:0] res_max_branch;
  logic [KEY_WIDTH-1:0] res_max_dept;

  assign pop           = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (cnt_r == '0) || ((cnt_r == CW'(1)) && out_chan.ready);
  assign take          = in_chan.valid && in_chan.ready;

  tlgs_acc #(
    .KEY_WIDTH (KEY_WIDTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_tlgs_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .action         (in_chan.action),
    .branch         (in_chan.branch),
    .department     (in_chan.department),
    .amount         (in_chan.amount),
    .res_cnt        (res_cnt),
    .res_kind       (res_kind),
    .res_branch     (res_branch),
    .res_dept       (res_dept),
    .res_total      (res_total),
    .res_max_valid  (res_max_valid),
    .res_max_branch (res_max_branch),
    .res_max_dept   (res_max_dept)
  );

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      fresh[i].kind = res_kind[i];
      fresh[i].br   = res_branch[i];
      fresh[i].dp   = res_dept[i];
      fresh[i].tot  = res_total[i];
      fresh[i].mv   = (res_kind[i] == tlgs_pkg::KIND_GRAND) ? res_max_valid : 1'b0;
      fresh[i].mb   = (res_kind[i] == tlgs_pkg::KIND_GRAND) ? res_max_branch : '0;
      fresh[i].md   = (res_kind[i] == tlgs_pkg::KIND_GRAND) ? res_max_dept : '0;
      fresh[i].last = (CW'(i + 1) == res_cnt);
    end
  end

  // Load on a request (slots are then empty or draining their last); else advance on pop.
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < NS; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (take) begin
      cnt_nxt = res_cnt;
      for (int i = 0; i < NS; i++) begin
        slot_nxt[i] = fresh[i];
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - CW'(1);
      for (int i = 0; i < NS - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign out_chan.valid          = (cnt_r != '0);
  assign out_chan.kind           = slot_r[0].kind;
  assign out_chan.branch_res     = slot_r[0].br;
  assign out_chan.department_res = slot_r[0].dp;
  assign out_chan.total          = slot_r[0].tot;
  assign out_chan.max_valid      = slot_r[0].mv;
  assign out_chan.max_branch     = slot_r[0].mb;
  assign out_chan.max_department = slot_r[0].md;
  assign out_chan.last           = slot_r[0].last;

endmodule

// File: hdl/tlgs_chk.sv
// Port-level checker for the group sum core, bound to the top level.
`include "two_level_group_sum_with_max_core_defines.svh"

module tlgs_chk #(
  parameter int KEY_WIDTH = tlgs_pkg::KEY_WIDTH_DEF,
  parameter int SUM_WIDTH = tlgs_pkg::SUM_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_kind,
  input logic [SUM_WIDTH-1:0] out_total,
  input logic                 out_max_valid,
  input logic [KEY_WIDTH-1:0] out_max_branch,
  input logic [KEY_WIDTH-1:0] out_max_department,
  input logic                 out_last
);

  logic                 out_wait;
  logic                 out_grand;
  logic                 max_clear;
  logic [SUM_WIDTH+2:0] out_head;

  assign out_wait  = out_valid && !out_ready;
  assign out_grand = out_valid && (out_kind == tlgs_pkg::KIND_GRAND);
  assign max_clear = !out_max_valid && (out_max_branch == '0) && (out_max_department == '0);
  assign out_head  = {out_kind, out_total, out_last};

  `TLGS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid)
  `TLGS_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_head))
  `TLGS_ASSERT(a_grand_last, out_grand |-> out_last)
  `TLGS_ASSERT(a_max_only_grand, out_valid && !out_grand |-> max_clear)
  `TLGS_ASSERT(a_idle_ready, !out_valid |-> in_ready)

endmodule

bind two_level_group_sum_with_max_core tlgs_chk #(
  .KEY_WIDTH (KEY_WIDTH),
  .SUM_WIDTH (SUM_WIDTH)
) u_tlgs_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_kind           (out_chan.kind),
  .out_total          (out_chan.total),
  .out_max_valid      (out_chan.max_valid),
  .out_max_branch     (out_chan.max_branch),
  .out_max_department (out_chan.max_department),
  .out_last           (out_chan.last)
);

// File: sim/tb_two_level_group_sum_with_max_core.sv
// Self-checking testbench for the two-level group sum core with largest department.
module tb_two_level_group_sum_with_max_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW = tlgs_pkg::KEY_WIDTH_DEF;
  localparam int SW = tlgs_pkg::SUM_WIDTH_DEF;
  localparam int AW = tlgs_pkg::AMOUNT_WIDTH;
  localparam int LONG_HOLD = 200;
  localparam int PHASE_REQS = 75;
  localparam int MAX_SHOWN = 10;
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_END = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [KW-1:0]        branch;
    logic [KW-1:0]        department;
    logic signed [AW-1:0] amount;
  } req_t;

  typedef struct packed {
    tlgs_pkg::tlgs_kind_t kind;
    logic [KW-1:0]        branch_res;
    logic [KW-1:0]        department_res;
    logic signed [SW-1:0] total;
    logic                 max_valid;
    logic [KW-1:0]        max_branch;
    logic [KW-1:0]        max_department;
    logic                 last;
  } total_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlgs_in_if #(.KEY_WIDTH(KW)) in_if ();
  tlgs_out_if #(.KEY_WIDTH(KW), .SUM_WIDTH(SW)) out_if ();

  two_level_group_sum_with_max_core #(
    .KEY_WIDTH(KW),
    .SUM_WIDTH(SW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t   pending[$];
  total_t totals_due[$];
  int     queued = 0;
  int     accepted = 0;
  int     fail_count = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  int     stall_asks = 0;
  int     stall_served = 0;
  int     hold_left = 0;
  bit     req_taken = 1'b0;

  // running totals of the open groups and the largest department so far
  logic                 grp_open;
  logic [KW-1:0]        open_branch;
  logic [KW-1:0]        open_dept;
  logic signed [SW-1:0] dept_acc;
  logic signed [SW-1:0] branch_acc;
  logic signed [SW-1:0] grand_acc;
  logic                 top_valid;
  logic signed [SW-1:0] top_sum;
  logic [KW-1:0]        top_branch;
  logic [KW-1:0]        top_dept;

  function automatic void clear_tally();
    grp_open = 1'b0;
    open_branch = '0;
    open_dept = '0;
    dept_acc = '0;
    branch_acc = '0;
    grand_acc = '0;
    top_valid = 1'b0;
    top_sum = '0;
    top_branch = '0;
    top_dept = '0;
  endfunction

  function automatic total_t dept_total(input logic fin);
    total_t t;
    t = '0;
    t.kind = tlgs_pkg::KIND_DEPT;
    t.branch_res = open_branch;
    t.department_res = open_dept;
    t.total = dept_acc;
    t.last = fin;
    // strictly greater only, so the earlier department wins a tie
    if (!top_valid || dept_acc > top_sum) begin
      top_valid = 1'b1;
      top_sum = dept_acc;
      top_branch = open_branch;
      top_dept = open_dept;
    end
    branch_acc = branch_acc + dept_acc;
    dept_acc = '0;
    return t;
  endfunction

  function automatic total_t branch_total(input logic fin);
    total_t t;
    t = '0;
    t.kind = tlgs_pkg::KIND_BRANCH;
    t.branch_res = open_branch;
    t.total = branch_acc;
    t.last = fin;
    grand_acc = grand_acc + branch_acc;
    branch_acc = '0;
    return t;
  endfunction

  function automatic void tally_request(input req_t r);
    total_t g;
    logic   brk;
    if (r.action == ACT_END) begin
      if (grp_open) begin
        totals_due.push_back(dept_total(1'b0));
        totals_due.push_back(branch_total(1'b0));
      end
      g = '0;
      g.kind = tlgs_pkg::KIND_GRAND;
      g.total = grand_acc;
      g.max_valid = top_valid;
      g.max_branch = top_valid ? top_branch : '0;
      g.max_department = top_valid ? top_dept : '0;
      g.last = 1'b1;
      totals_due.push_back(g);
      clear_tally();
    end else begin
      if (grp_open && (r.branch != open_branch || r.department != open_dept)) begin
        brk = (r.branch != open_branch);
        totals_due.push_back(dept_total(!brk));
        if (brk) totals_due.push_back(branch_total(1'b1));
      end
      grp_open = 1'b1;
      open_branch = r.branch;
      open_dept = r.department;
      dept_acc = dept_acc + {{(SW-AW){r.amount[AW-1]}}, r.amount};
    end
  endfunction

  function automatic string fmt_total(input total_t t);
    return $sformatf("kind=%0d br=%h dp=%h tot=%h mv=%b mb=%h md=%h last=%b",
                     t.kind, t.branch_res, t.department_res, t.total, t.max_valid,
                     t.max_branch, t.max_department, t.last);
  endfunction

  // request driver: offer at the falling edge, note acceptance at the rising edge
  always begin : req_driver
    req_t nxt;
    req_t got;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.action <= ACT_RECORD;
      in_if.branch <= '0;
      in_if.department <= '0;
      in_if.amount <= '0;
    end else if (!in_if.valid || req_taken) begin
      if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending.pop_front();
        in_if.action <= nxt.action;
        in_if.branch <= nxt.branch;
        in_if.department <= nxt.department;
        in_if.amount <= nxt.amount;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    @(posedge clk);
    req_taken = rst_n && in_if.valid && in_if.ready;
    if (req_taken) begin
      got.action = in_if.action;
      got.branch = in_if.branch;
      got.department = in_if.department;
      got.amount = in_if.amount;
      tally_request(got);
      accepted++;
    end
    @(negedge clk);
  end

  always begin : result_sink
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_asks != stall_served) begin
      // long hold-off: let the result slots fill and back-pressure the input
      stall_served++;
      hold_left = LONG_HOLD - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
    @(negedge clk);
  end

  always @(posedge clk) begin : total_monitor
    total_t seen;
    total_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.kind = out_if.kind;
      seen.branch_res = out_if.branch_res;
      seen.department_res = out_if.department_res;
      seen.total = out_if.total;
      seen.max_valid = out_if.max_valid;
      seen.max_branch = out_if.max_branch;
      seen.max_department = out_if.max_department;
      seen.last = out_if.last;
      if (totals_due.size() == 0) begin
        if (fail_count < MAX_SHOWN)
          $display("%0t unexpected result: %s", $time, fmt_total(seen));
        fail_count++;
      end else begin
        want = totals_due.pop_front();
        if (seen !== want) begin
          if (fail_count < MAX_SHOWN) begin
            $display("%0t mismatch exp: %s", $time, fmt_total(want));
            $display("%0t mismatch got: %s", $time, fmt_total(seen));
          end
          fail_count++;
        end
      end
    end
  end

  function automatic void queue_request(input logic act, input logic [KW-1:0] br,
                                        input logic [KW-1:0] dp,
                                        input logic signed [AW-1:0] amt);
    req_t r;
    r.action = act;
    r.branch = br;
    r.department = dp;
    r.amount = amt;
    pending.push_back(r);
    queued++;
  endfunction

  function automatic logic signed [AW-1:0] pick_amount();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return AW'($signed($urandom_range(200)) - 100);
      3: return AW'($urandom_range(99999));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return KW'($urandom_range(3));
      default: return KW'($urandom);
    endcase
  endfunction

  // sorted stream: branches ascending, departments ascending within each branch
  task automatic queue_stream();
    int            nb;
    int            nd;
    int            nr;
    logic [KW-1:0] br;
    logic [KW-1:0] dp;
    nb = $urandom_range(1, 4);
    br = KW'($urandom_range(0, 40000));
    for (int b = 0; b < nb; b++) begin
      if (b > 0) br = br + KW'($urandom_range(1, 6000));
      dp = KW'($urandom_range(0, 40000));
      nd = $urandom_range(1, 4);
      for (int d = 0; d < nd; d++) begin
        if (d > 0) dp = dp + KW'($urandom_range(1, 6000));
        nr = ($urandom_range(3) == 0) ? $urandom_range(2, 5) : 1;
        for (int k = 0; k < nr; k++)
          queue_request(ACT_RECORD, br, dp, pick_amount());
      end
    end
    if ($urandom_range(7) != 0)
      queue_request(ACT_END, KW'($urandom), KW'($urandom), $urandom);
  endtask

  // unsorted keys and stray end markers
  task automatic queue_noise();
    int n;
    n = $urandom_range(2, 8);
    for (int k = 0; k < n; k++)
      queue_request(($urandom_range(4) == 0) ? ACT_END : ACT_RECORD, pick_key(), pick_key(),
                    pick_amount());
  endtask

  task automatic drain();
    while (accepted != queued || totals_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int src_pct, input int snk_pct, input bit long_hold);
    int start;
    start = queued;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (queued - start < PHASE_REQS) begin
      if ($urandom_range(5) == 0) queue_noise();
      else queue_stream();
    end
    if (long_hold) stall_asks++;
    drain();
  endtask

  initial begin
    clear_tally();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 7;
    snk_idle_pct = 82;
    // end marker with nothing open
    queue_request(ACT_END, '1, '1, 32'sh7FFF_FFFF);
    queue_request(ACT_RECORD, '0, '0, 32'sh7FFF_FFFF);
    queue_request(ACT_RECORD, '0, '0, 32'sh7FFF_FFFF);
    queue_request(ACT_RECORD, '0, '1, 32'sh8000_0000);
    queue_request(ACT_RECORD, '0, '1, -32'sd1);
    // branch change with the department id kept
    queue_request(ACT_RECORD, '1, '1, 32'sh5555_5555);
    queue_request(ACT_RECORD, 16'hAAAA, 16'h5555, 32'shAAAA_AAAA);
    queue_request(ACT_END, '0, '0, '0);
    // tie on the largest department: the first one stays
    queue_request(ACT_RECORD, 16'd1, 16'd1, 32'sd100);
    queue_request(ACT_RECORD, 16'd1, 16'd2, 32'sd100);
    queue_request(ACT_RECORD, 16'd2, 16'd1, -32'sd5);
    queue_request(ACT_END, '1, '0, -32'sd1);
    // only negative totals
    queue_request(ACT_RECORD, 16'd3, 16'd3, -32'sd7);
    queue_request(ACT_RECORD, 16'd3, 16'd3, -32'sd9);
    queue_request(ACT_END, '0, '1, '0);
    queue_request(ACT_END, '0, '0, '0);
    queue_request(ACT_RECORD, 16'h8000, 16'h0001, 32'sd1);
    queue_request(ACT_RECORD, 16'h8000, 16'h0001, -32'sd1);
    queue_request(ACT_RECORD, 16'h8000, 16'h0002, 32'sd0);
    queue_request(ACT_END, '0, '0, '0);
    drain();

    run_random(7, 82, 1'b0);
    run_random(82, 7, 1'b0);
    run_random(0, 0, 1'b1);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && totals_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
